// File: hdl/lrt_pkg.sv
package lrt_pkg;

  localparam int ID_W = 64;

  typedef enum logic [1:0] {
    FN_HIT    = 2'd0,
    FN_INSERT = 2'd1,
    FN_EVICT  = 2'd2,
    FN_REMOVE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ABSENT  = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef struct packed {
    func_t            func;
    logic [ID_W-1:0]  object_id;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]  dropped_id;
    logic             evicted_valid;
    status_t          status;
  } out_t;

  // Successful operations broadcast to every entry
  typedef struct packed {
    logic hit;
    logic ins;
    logic rem;
    logic evc;
  } lrt_cmd_t;

endpackage

// File: hdl/lrt_entry.sv
module lrt_entry import lrt_pkg::*; #(
  parameter int RANK_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lrt_cmd_t          cmd,
  input  logic [RANK_W-1:0] ref_rank,
  input  logic [ID_W-1:0]   key,
  input  logic              ins_sel,
  output logic              valid,
  output logic [RANK_W-1:0] rank,
  output logic [ID_W-1:0]   id,
  output logic              match,
  output logic              rank_eq
);

  logic              valid_r, valid_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [ID_W-1:0]   id_r;
  logic              id_we;

  assign match   = valid_r && (id_r == key);
  assign rank_eq = valid_r && (rank_r == ref_rank);
  assign valid   = valid_r;
  assign rank    = rank_r;
  assign id      = id_r;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    id_we     = 1'b0;
    if (cmd.hit) begin
      if (match) begin
        rank_nxt = '0;
      end else if (valid_r && (rank_r < ref_rank)) begin
        rank_nxt = RANK_W'(rank_r + 1'b1);
      end
    end else if (cmd.ins) begin
      if (ins_sel) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
        id_we     = 1'b1;
      end else if (valid_r) begin
        rank_nxt = RANK_W'(rank_r + 1'b1);
      end
    end else if (cmd.rem) begin
      if (match) begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end else if (valid_r && (rank_r > ref_rank)) begin
        rank_nxt = RANK_W'(rank_r - 1'b1);
      end
    end else if (cmd.evc) begin
      if (rank_eq) begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_r <= key;
    end
  end

endmodule

// File: hdl/lru_replacement_table.sv
// Fully associative LRU table over up to CAPACITY 64-bit object ids. Events
// (hit, insert, evict least recent, remove) are taken one per cycle; each gives
// one result, passing through an input register and then a result register.
// All entries compare the id and update their recency rank in parallel
// between those registers, so one event per clock is sustained whenever the
// result side keeps taking transfers. Errors (absent id, full, empty,
// duplicate insert) leave the table unchanged.
module lru_replacement_table import lrt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  in_t               in_r;
  logic              in_v_r, in_v_nxt;
  out_t              out_r, out_nxt;
  logic              out_v_r, out_v_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              adv, fire;
  lrt_cmd_t          cmd;
  logic [RANK_W-1:0] ref_rank;
  logic [RANK_W-1:0] hit_rank;
  logic [RANK_W-1:0] last_rank;
  logic [ID_W-1:0]   victim_id;
  logic              any_match, full, empty;
  status_t           status;

  logic [CAPACITY-1:0] valid_vec, match_vec, eq_vec, free_vec, slot_vec;
  logic [RANK_W-1:0]   rank_arr [CAPACITY];
  logic [ID_W-1:0]     id_arr   [CAPACITY];

  assign adv      = !out_v_r || out_ready;
  assign fire     = in_v_r && adv;
  assign in_ready = !in_v_r || adv;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_entry
      lrt_entry #(.RANK_W(RANK_W)) u_entry (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .ref_rank (ref_rank),
        .key      (in_r.object_id),
        .ins_sel  (slot_vec[g]),
        .valid    (valid_vec[g]),
        .rank     (rank_arr[g]),
        .id       (id_arr[g]),
        .match    (match_vec[g]),
        .rank_eq  (eq_vec[g])
      );
    end
  endgenerate

  assign free_vec  = ~valid_vec;
  assign slot_vec  = free_vec & (~free_vec + CAPACITY'(1));
  assign any_match = |match_vec;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign last_rank = RANK_W'(count_r - 1'b1);

  always_comb begin
    hit_rank  = '0;
    victim_id = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        hit_rank = hit_rank | rank_arr[i];
      end
      if (eq_vec[i]) begin
        victim_id = victim_id | id_arr[i];
      end
    end
  end

  always_comb begin
    cmd      = '0;
    status   = ST_OK;
    ref_rank = hit_rank;
    unique case (in_r.func)
      FN_HIT: begin
        status  = any_match ? ST_OK : ST_ABSENT;
        cmd.hit = fire && any_match;
      end
      FN_INSERT: begin
        if (any_match) begin
          status = ST_PRESENT;
        end else if (full) begin
          status = ST_FULL;
        end
        cmd.ins = fire && !any_match && !full;
      end
      FN_EVICT: begin
        status   = empty ? ST_EMPTY : ST_OK;
        ref_rank = last_rank;
        cmd.evc  = fire && !empty;
      end
      FN_REMOVE: begin
        status  = any_match ? ST_OK : ST_ABSENT;
        cmd.rem = fire && any_match;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (cmd.rem || cmd.evc) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_comb begin
    out_nxt.status        = status;
    out_nxt.evicted_valid = (in_r.func == FN_EVICT) && !empty;
    out_nxt.dropped_id    = out_nxt.evicted_valid ? victim_id : '0;
  end

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      count_r <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("entry count differs from valid entries");

  a_unique_id: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("id held by more than one entry");

  a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.evc |-> $onehot(eq_vec))
    else $error("evict without a single least recent entry");

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrt_pkg::*;

  localparam int CAP = 64;
  localparam int RANDOM_EVENTS = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;
  typedef enum {RX_OPEN, RX_COIN, RX_PATTERN} rx_mode_t;

  typedef struct {
    in_t ev;
    bit  drain_first;
  } queued_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  queued_event_t queued_events[$];
  out_t awaited_results[$];

  logic [ID_W-1:0] recency_order[$];
  logic [ID_W-1:0] retired_ids[$];

  logic [ID_W-1:0] lru_id[CAP];
  logic            lru_vld[CAP];
  logic [5:0]      lru_rank[CAP];
  logic [6:0]      lru_count;

  logic     in_taken = 1'b0;
  int       gap_left = 0;
  int       burst_left = 1;
  int       phase_left = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  rx_mode_t rx_mode = RX_OPEN;
  logic [7:0] rx_pattern = 8'b1011_0010;

  int unsigned events_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned evictions = 0;
  int unsigned quiet_cycles = 0;
  int unsigned status_tally[0:4] = '{default: 0};
  out_t next_result;

  lru_replacement_table #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic out_t lru_apply(in_t ev);
    out_t res;
    int slot;
    int free_slot;
    logic [5:0] r;
    bit found;
    res = '0;
    res.status = ST_OK;
    slot = -1;
    free_slot = -1;
    found = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      if (lru_vld[i] && lru_id[i] == ev.object_id) slot = i;
      if (!lru_vld[i] && free_slot < 0) free_slot = i;
    end
    case (ev.func)
      FN_HIT: begin
        if (slot < 0) begin
          res.status = ST_ABSENT;
        end else begin
          r = lru_rank[slot];
          for (int i = 0; i < CAP; i++)
            if (lru_vld[i] && lru_rank[i] < r) lru_rank[i] = lru_rank[i] + 6'd1;
          lru_rank[slot] = '0;
        end
      end
      FN_INSERT: begin
        if (slot >= 0) begin
          res.status = ST_PRESENT;
        end else if (free_slot < 0) begin
          res.status = ST_FULL;
        end else begin
          for (int i = 0; i < CAP; i++)
            if (lru_vld[i]) lru_rank[i] = lru_rank[i] + 6'd1;
          lru_vld[free_slot] = 1'b1;
          lru_id[free_slot] = ev.object_id;
          lru_rank[free_slot] = '0;
          lru_count = lru_count + 7'd1;
        end
      end
      FN_EVICT: begin
        if (lru_count == 7'd0) begin
          res.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < CAP; i++) begin
            if (!found && lru_vld[i] && {1'b0, lru_rank[i]} == lru_count - 7'd1) begin
              res.dropped_id = lru_id[i];
              res.evicted_valid = 1'b1;
              lru_vld[i] = 1'b0;
              lru_rank[i] = '0;
              found = 1'b1;
            end
          end
          if (found) lru_count = lru_count - 7'd1;
          else res.status = ST_EMPTY;
        end
      end
      default: begin
        if (slot < 0) begin
          res.status = ST_ABSENT;
        end else begin
          r = lru_rank[slot];
          for (int i = 0; i < CAP; i++)
            if (lru_vld[i] && lru_rank[i] > r) lru_rank[i] = lru_rank[i] - 6'd1;
          lru_vld[slot] = 1'b0;
          lru_rank[slot] = '0;
          lru_count = lru_count - 7'd1;
        end
      end
    endcase
    return res;
  endfunction

  function automatic int order_find(logic [ID_W-1:0] id);
    for (int i = 0; i < recency_order.size(); i++)
      if (recency_order[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    if (retired_ids.size() != 0 && $urandom_range(0, 99) < 15)
      return retired_ids[$urandom_range(0, retired_ids.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ID_W-1:0] live_id();
    if (recency_order.size() == 0) return {$urandom, $urandom};
    return recency_order[$urandom_range(0, recency_order.size() - 1)];
  endfunction

  function automatic logic [ID_W-1:0] dead_id();
    if (retired_ids.size() != 0 && $urandom_range(0, 1) == 1)
      return retired_ids[$urandom_range(0, retired_ids.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic add_event(func_t f, logic [ID_W-1:0] id, bit drain);
    queued_event_t item;
    int k;
    k = order_find(id);
    case (f)
      FN_HIT: begin
        if (k >= 0) begin
          recency_order.delete(k);
          recency_order.push_front(id);
        end
      end
      FN_INSERT: begin
        if (k < 0 && recency_order.size() < CAP) recency_order.push_front(id);
      end
      FN_EVICT: begin
        if (recency_order.size() != 0) retired_ids.push_back(recency_order.pop_back());
      end
      default: begin
        if (k >= 0) begin
          retired_ids.push_back(id);
          recency_order.delete(k);
        end
      end
    endcase
    if (retired_ids.size() > 32) retired_ids.delete(0);
    item.ev.func = f;
    item.ev.object_id = id;
    item.drain_first = drain;
    queued_events.push_back(item);
  endtask

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (queued_events.size() != 0 &&
                   !(queued_events[0].drain_first && awaited_results.size() != 0)) begin
        in_valid <= 1'b1;
        in_data <= queued_events[0].ev;
        queued_events.delete(0);
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (phase_left == 0) begin
      phase_left <= $urandom_range(16, 80);
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_pattern <= 8'($urandom_range(1, 255));
      out_ready <= 1'b1;
    end else begin
      phase_left <= phase_left - 1;
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready <= rx_pattern[0];
          rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (out_valid && out_ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_data);
        mismatches++;
      end else begin
        next_result = awaited_results.pop_front();
        status_tally[next_result.status]++;
        if (next_result.evicted_valid) evictions++;
        if (out_data.dropped_id !== next_result.dropped_id) begin
          $error("dropped_id: expected %h, got %h", next_result.dropped_id,
                 out_data.dropped_id);
          mismatches++;
        end
        if (out_data.evicted_valid !== next_result.evicted_valid) begin
          $error("evicted_valid: expected %b, got %b", next_result.evicted_valid,
                 out_data.evicted_valid);
          mismatches++;
        end
        if (out_data.status !== next_result.status) begin
          $error("status: expected %0d, got %0d", next_result.status, out_data.status);
          mismatches++;
        end
      end
    end
    if (in_valid && in_ready) begin
      awaited_results.push_back(lru_apply(in_data));
      events_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, awaited_results.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    int len;
    int pick;
    int round;
    mix_t mode;
    func_t f;
    logic [ID_W-1:0] id;
    bit drain;

    for (int i = 0; i < CAP; i++) begin
      lru_id[i] = '0;
      lru_vld[i] = 1'b0;
      lru_rank[i] = '0;
    end
    lru_count = '0;

    add_event(FN_EVICT, '0, 1'b0);
    add_event(FN_HIT, '0, 1'b0);
    add_event(FN_REMOVE, '1, 1'b0);
    add_event(FN_INSERT, '0, 1'b0);
    add_event(FN_INSERT, '1, 1'b0);
    add_event(FN_INSERT, '0, 1'b0);
    add_event(FN_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    add_event(FN_INSERT, 64'h5555_5555_5555_5555, 1'b0);
    add_event(FN_HIT, '0, 1'b0);
    add_event(FN_EVICT, '0, 1'b0);
    add_event(FN_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    add_event(FN_HIT, '1, 1'b0);
    add_event(FN_INSERT, 64'h8000_0000_0000_0001, 1'b0);
    add_event(FN_EVICT, '1, 1'b0);
    add_event(FN_HIT, 64'h8000_0000_0000_0001, 1'b0);
    add_event(FN_EVICT, 64'h1234_5678_9ABC_DEF0, 1'b0);
    add_event(FN_EVICT, '0, 1'b0);
    add_event(FN_EVICT, '0, 1'b0);
    add_event(FN_REMOVE, '0, 1'b0);
    add_event(FN_HIT, {$urandom, $urandom}, 1'b0);

    n = 0;
    round = 0;
    while (n < RANDOM_EVENTS) begin
      mode = (round == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      len = (mode == MIX_CHURN) ? $urandom_range(30, 80) : $urandom_range(90, 130);
      for (int j = 0; j < len; j++) begin
        pick = $urandom_range(0, 99);
        drain = (j == 0) && (round == 0 || $urandom_range(0, 3) == 0);
        f = FN_EVICT;
        id = {$urandom, $urandom};
        case (mode)
          MIX_FILL: begin
            if (pick < 80) begin f = FN_INSERT; id = fresh_id(); end
            else if (pick < 86) begin f = FN_INSERT; id = live_id(); end
            else if (pick < 95) begin f = FN_HIT; id = live_id(); end
          end
          MIX_CHURN: begin
            if (pick < 30) begin f = FN_HIT; id = live_id(); end
            else if (pick < 40) begin f = FN_HIT; id = dead_id(); end
            else if (pick < 60) begin f = FN_INSERT; id = fresh_id(); end
            else if (pick < 65) begin f = FN_INSERT; id = live_id(); end
            else if (pick < 78) begin f = FN_REMOVE; id = live_id(); end
            else if (pick < 84) begin f = FN_REMOVE; id = dead_id(); end
          end
          default: begin
            if (pick < 45) f = FN_EVICT;
            else if (pick < 80) begin f = FN_REMOVE; id = live_id(); end
            else if (pick < 88) begin f = FN_REMOVE; id = dead_id(); end
            else if (pick < 95) begin f = FN_HIT; id = live_id(); end
            else begin f = FN_INSERT; id = fresh_id(); end
          end
        endcase
        add_event(f, id, drain);
      end
      n += len;
      round++;
    end

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (queued_events.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d events: %0d ok, %0d absent, %0d full, %0d empty, %0d duplicate",
             events_taken, status_tally[0], status_tally[1], status_tally[2],
             status_tally[3], status_tally[4]);
    $display("%0d evictions returned; one %0d-cycle result hold-off and idle-drained pauses",
             evictions, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/lrt_pkg.sv
hdl/lrt_entry.sv
hdl/lru_replacement_table.sv
tb/tb_top.sv
